FILE: src/sddt_pkg.sv
// Shared types and constants of the stepper direct-drive torque block.
// Used by sddt_scale, sddt_front and stepper_direct_drive_torque; depends on nothing.

package sddt_pkg;

    localparam int TORQUE_W     = 15;
    localparam int TORQUE_OUT_W = 16;
    localparam int OFFSET_W     = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT_MAX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd5;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX_RESET = 16'hFFFF;

    typedef struct packed {
        logic neg;
        logic in_dz;
        logic below;
    } front_flags_t;

endpackage

FILE: src/sddt_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the caller guarantees the quotient fits QUO_W bits.

module sddt_div #(
    parameter int DIV_W  = 16,
    parameter int QUO_W  = 15,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DIV_W+QUO_W-1:0] dividend,
    input  logic [DIV_W-1:0]       divisor,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [QUO_W-1:0]       quotient,
    output logic [SIDE_W-1:0]      out_side
);

    logic [QUO_W-1:0]  v_reg;
    logic [QUO_W:0]    rdy;
    logic [DIV_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];
    logic [DIV_W-1:0]  rem_src   [QUO_W];
    logic [QUO_W-1:0]  low_src   [QUO_W];
    logic [QUO_W-1:0]  quo_src   [QUO_W];
    logic [SIDE_W-1:0] side_src  [QUO_W];
    logic [QUO_W-1:0]  v_src;
    logic [DIV_W:0]    trial     [QUO_W];
    logic [DIV_W:0]    diff      [QUO_W];
    logic [QUO_W-1:0]  ge;
    logic [DIV_W-1:0]  rem_next  [QUO_W];
    logic [QUO_W-1:0]  low_next  [QUO_W];
    logic [QUO_W-1:0]  quo_next  [QUO_W];

    always_comb
    begin
        rdy[QUO_W] = out_ready;
        for (int k = QUO_W - 1; k >= 0; k--)
        begin
            rdy[k] = ~v_reg[k] | rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        rem_src[0]  = dividend[DIV_W+QUO_W-1:QUO_W];
        low_src[0]  = dividend[QUO_W-1:0];
        quo_src[0]  = '0;
        side_src[0] = in_side;
        v_src[0]    = in_valid;
        for (int k = 1; k < QUO_W; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            low_src[k]  = low_reg[k-1];
            quo_src[k]  = quo_reg[k-1];
            side_src[k] = side_reg[k-1];
            v_src[k]    = v_reg[k-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            trial[k]    = {rem_src[k], low_src[k][QUO_W-1]};
            diff[k]     = trial[k] - {1'b0, divisor};
            ge[k]       = trial[k] >= {1'b0, divisor};
            rem_next[k] = ge[k] ? diff[k][DIV_W-1:0] : trial[k][DIV_W-1:0];
            low_next[k] = low_src[k] << 1;
            quo_next[k] = {quo_src[k][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_src[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign quotient  = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

FILE: src/sddt_scale.sv
// Torque scaling unit: one multiply stage, then a pipelined divide.
// Depends on sddt_pkg and sddt_div.

module sddt_scale #(
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sddt_pkg::TORQUE_W-1:0] in_tmag,
    input  logic [sddt_pkg::OFFSET_W-1:0] in_factor,
    input  logic                          in_apply,
    input  logic [SIDE_W-1:0]             in_side,
    input  logic [sddt_pkg::OFFSET_W-1:0] divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sddt_pkg::TORQUE_W-1:0] out_tmag,
    output logic [SIDE_W-1:0]             out_side
);

    import sddt_pkg::*;

    localparam int PROD_W = TORQUE_W + OFFSET_W;
    localparam int PASS_W = SIDE_W + TORQUE_W + 1;

    logic                mul_v_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [TORQUE_W-1:0] tmag_reg;
    logic                apply_reg;
    logic [SIDE_W-1:0]   side_reg;
    logic                mul_rdy;
    logic                div_in_ready;
    logic [TORQUE_W-1:0] quotient;
    logic [PASS_W-1:0]   div_side;
    logic [TORQUE_W-1:0] tmag_pass;
    logic                apply_pass;

    assign mul_rdy   = ~mul_v_reg | div_in_ready;
    assign in_ready  = mul_rdy;
    assign prod_next = PROD_W'(in_tmag) * PROD_W'(in_factor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
        end
        else if (mul_rdy)
        begin
            mul_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_rdy)
        begin
            prod_reg  <= prod_next;
            tmag_reg  <= in_tmag;
            apply_reg <= in_apply;
            side_reg  <= in_side;
        end
    end

    sddt_div #(
        .DIV_W  (OFFSET_W),
        .QUO_W  (TORQUE_W),
        .SIDE_W (PASS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_v_reg),
        .in_ready  (div_in_ready),
        .dividend  (prod_reg),
        .divisor   (divisor),
        .in_side   ({side_reg, tmag_reg, apply_reg}),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quotient  (quotient),
        .out_side  (div_side)
    );

    assign {out_side, tmag_pass, apply_pass} = div_side;
    assign out_tmag = apply_pass ? quotient : tmag_pass;

endmodule

FILE: src/sddt_front.sv
// Front pipeline: target clamp, position error, drive offset by reciprocal
// multiply, and the dead-zone and minimum-offset decisions. Depends on sddt_pkg.

module sddt_front #(
    parameter int POSITION_BITS = 24,
    parameter int ENCODER_BITS  = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [POSITION_BITS-1:0]   soft_limit_max,
    input  logic signed [POSITION_BITS-1:0]   soft_limit_min,
    input  logic [sddt_pkg::TORQUE_W-1:0]     max_torque,
    input  logic [sddt_pkg::OFFSET_W-1:0]     offset_min,
    input  logic [sddt_pkg::OFFSET_W-1:0]     offset_max,
    input  logic [sddt_pkg::OFFSET_W-1:0]     dead_zone,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [POSITION_BITS-1:0]   target_pos,
    input  logic signed [POSITION_BITS-1:0]   measured_pos,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sddt_pkg::TORQUE_W-1:0]     out_tmag,
    output logic [sddt_pkg::OFFSET_W-1:0]     out_fac_dz,
    output logic [sddt_pkg::OFFSET_W-1:0]     out_fac_min,
    output logic [sddt_pkg::OFFSET_W-1:0]     out_offset,
    output sddt_pkg::front_flags_t            out_flags
);

    import sddt_pkg::*;

    localparam int PB          = POSITION_BITS;
    localparam int PHASE_SHIFT = 8;
    localparam int STEP_CYCLE  = (4 * (1 << ENCODER_BITS)) / 200;
    localparam int C_W         = $clog2(STEP_CYCLE + 1);
    localparam int Q_W         = PB + PHASE_SHIFT - (C_W - 1);
    localparam int O_W         = (Q_W > OFFSET_W) ? Q_W : OFFSET_W;
    localparam int PROD_W      = PB + Q_W;
    localparam int QC_W        = Q_W + C_W + 1;
    localparam longint unsigned RECIP_L = (64'd1 << (PB + PHASE_SHIFT)) / STEP_CYCLE;
    localparam logic [Q_W-1:0]  RECIP   = Q_W'(RECIP_L);
    localparam int STAGES      = 6;

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   rdy;

    logic signed [PB-1:0] tgt_reg;
    logic signed [PB-1:0] meas_reg;
    logic signed [PB-1:0] tgt_next;
    logic                 clamp_on;

    logic [PB:0]          d_pos;
    logic [PB:0]          d_neg;
    logic [PB-1:0]        dist1_reg;
    logic                 neg1_reg;

    logic [PROD_W-1:0]    prod_reg;
    logic [PB-1:0]        dist2_reg;
    logic                 neg2_reg;

    logic [Q_W-1:0]       q0_next;
    logic [QC_W-1:0]      qc1_next;
    logic [Q_W-1:0]       q0_reg;
    logic [QC_W-1:0]      qc1_reg;
    logic [PB-1:0]        dist3_reg;
    logic                 neg3_reg;

    logic [QC_W-1:0]      scaled;
    logic [Q_W-1:0]       q_next;
    logic [Q_W-1:0]       q_reg;
    logic [PB-1:0]        dist4_reg;
    logic                 neg4_reg;

    logic [O_W-1:0]       q_ext;
    logic [O_W-1:0]       sel_off;
    logic                 below;
    logic                 in_dz;
    logic [TORQUE_W-1:0]  tmag_reg;
    logic [OFFSET_W-1:0]  fac_dz_reg;
    logic [OFFSET_W-1:0]  fac_min_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [OFFSET_W-1:0]  offset_next;
    front_flags_t         flags_reg;

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = ~v_reg[k] | rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Limits only take effect when they are ordered.
    assign clamp_on = soft_limit_max > soft_limit_min;

    always_comb
    begin
        tgt_next = target_pos;
        if (clamp_on && (target_pos > soft_limit_max))
        begin
            tgt_next = soft_limit_max;
        end
        else if (clamp_on && (target_pos < soft_limit_min))
        begin
            tgt_next = soft_limit_min;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            tgt_reg  <= tgt_next;
            meas_reg <= measured_pos;
        end
    end

    assign d_pos = {tgt_reg[PB-1], tgt_reg} - {meas_reg[PB-1], meas_reg};
    assign d_neg = {meas_reg[PB-1], meas_reg} - {tgt_reg[PB-1], tgt_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            neg1_reg  <= d_pos[PB];
            dist1_reg <= d_pos[PB] ? d_neg[PB-1:0] : d_pos[PB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            prod_reg  <= PROD_W'(dist1_reg) * PROD_W'(RECIP);
            dist2_reg <= dist1_reg;
            neg2_reg  <= neg1_reg;
        end
    end

    // The reciprocal estimate is the true quotient or one below it.
    assign q0_next  = prod_reg[PROD_W-1:PB];
    assign qc1_next = (QC_W'(q0_next) + QC_W'(1)) * QC_W'(STEP_CYCLE);

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            q0_reg    <= q0_next;
            qc1_reg   <= qc1_next;
            dist3_reg <= dist2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    assign scaled = QC_W'({dist3_reg, {PHASE_SHIFT{1'b0}}});
    assign q_next = (scaled >= qc1_reg) ? (q0_reg + Q_W'(1)) : q0_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            q_reg     <= q_next;
            dist4_reg <= dist3_reg;
            neg4_reg  <= neg3_reg;
        end
    end

    assign q_ext   = O_W'(q_reg);
    assign below   = q_ext < O_W'(offset_min);
    assign in_dz   = dist4_reg < PB'(dead_zone);
    assign sel_off = below ? O_W'(offset_min) : q_ext;
    assign offset_next = (sel_off > O_W'(offset_max)) ? offset_max : sel_off[OFFSET_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            tmag_reg        <= (|q_reg) ? max_torque : '0;
            fac_dz_reg      <= dist4_reg[OFFSET_W-1:0];
            fac_min_reg     <= q_ext[OFFSET_W-1:0];
            offset_reg      <= offset_next;
            flags_reg.neg   <= neg4_reg;
            flags_reg.in_dz <= in_dz;
            flags_reg.below <= below;
        end
    end

    assign out_valid   = v_reg[STAGES-1];
    assign out_tmag    = tmag_reg;
    assign out_fac_dz  = fac_dz_reg;
    assign out_fac_min = fac_min_reg;
    assign out_offset  = offset_reg;
    assign out_flags   = flags_reg;

endmodule

FILE: src/stepper_direct_drive_torque.sv
// An accepted input item passes the front pipeline, both scaling units and the output register.
// Throughput: one item per cycle; each stage stalls only when it is full and the
// stage after it is stalled, so bubbles close up behind a waiting result.
// The two 15-stage dividers for dead-zone and minimum-offset scaling set the latency.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// register defaults: all zero except offset_max at 65535.

module stepper_direct_drive_torque #(
    parameter int  POSITION_BITS = 24,
    parameter int  ENCODER_BITS  = 14,
    localparam int IN_W          = ((2 * POSITION_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sddt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sddt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sddt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: target_pos, measured_pos, zero padding.
    input  logic [IN_W-1:0]                     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: torque_out, drive_offset.
    output logic [sddt_pkg::TORQUE_OUT_W+sddt_pkg::OFFSET_W-1:0] m_axis_tdata
);

    import sddt_pkg::*;

    localparam int PB     = POSITION_BITS;
    localparam int SIDE1_W = 2 * OFFSET_W + 2;
    localparam int SIDE2_W = OFFSET_W + 1;
    localparam int OUT_W   = TORQUE_OUT_W + OFFSET_W;

    logic signed [PB-1:0]  soft_max_reg;
    logic signed [PB-1:0]  soft_min_reg;
    logic [TORQUE_W-1:0]   max_torque_reg;
    logic [OFFSET_W-1:0]   offset_min_reg;
    logic [OFFSET_W-1:0]   offset_max_reg;
    logic [OFFSET_W-1:0]   dead_zone_reg;
    logic                  cfg_wr;
    logic [CFG_IDX_W-1:0]  cfg_idx;

    logic                  fr_valid;
    logic                  fr_ready;
    logic [TORQUE_W-1:0]   fr_tmag;
    logic [OFFSET_W-1:0]   fr_fac_dz;
    logic [OFFSET_W-1:0]   fr_fac_min;
    logic [OFFSET_W-1:0]   fr_offset;
    front_flags_t          fr_flags;

    logic                  s1_valid;
    logic                  s1_ready;
    logic [TORQUE_W-1:0]   s1_tmag;
    logic [SIDE1_W-1:0]    s1_side;
    logic [OFFSET_W-1:0]   s1_fac_min;
    logic [OFFSET_W-1:0]   s1_offset;
    logic                  s1_neg;
    logic                  s1_below;

    logic                  s2_valid;
    logic [TORQUE_W-1:0]   s2_tmag;
    logic [SIDE2_W-1:0]    s2_side;
    logic [OFFSET_W-1:0]   s2_offset;
    logic                  s2_neg;

    logic                  out_v_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_rdy;
    logic [TORQUE_OUT_W-1:0] tq_ext;
    logic [TORQUE_OUT_W-1:0] torque_next;

    logic signed [TORQUE_OUT_W-1:0] out_torque;
    logic [TORQUE_OUT_W-1:0]        out_torque_mag;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_max_reg   <= '0;
            soft_min_reg   <= '0;
            max_torque_reg <= '0;
            offset_min_reg <= '0;
            offset_max_reg <= OFFSET_MAX_RESET;
            dead_zone_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SOFT_LIMIT_MAX: soft_max_reg   <= pwdata[PB-1:0];
                REG_SOFT_LIMIT_MIN: soft_min_reg   <= pwdata[PB-1:0];
                REG_MAX_TORQUE:     max_torque_reg <= pwdata[TORQUE_W-1:0];
                REG_OFFSET_MIN:     offset_min_reg <= pwdata[OFFSET_W-1:0];
                REG_OFFSET_MAX:     offset_max_reg <= pwdata[OFFSET_W-1:0];
                REG_DEAD_ZONE:      dead_zone_reg  <= pwdata[OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SOFT_LIMIT_MAX: prdata = CFG_DATA_W'(soft_max_reg);
            REG_SOFT_LIMIT_MIN: prdata = CFG_DATA_W'(soft_min_reg);
            REG_MAX_TORQUE:     prdata = CFG_DATA_W'(max_torque_reg);
            REG_OFFSET_MIN:     prdata = CFG_DATA_W'(offset_min_reg);
            REG_OFFSET_MAX:     prdata = CFG_DATA_W'(offset_max_reg);
            REG_DEAD_ZONE:      prdata = CFG_DATA_W'(dead_zone_reg);
            default:            prdata = '0;
        endcase
    end

    sddt_front #(
        .POSITION_BITS (POSITION_BITS),
        .ENCODER_BITS  (ENCODER_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .soft_limit_max (soft_max_reg),
        .soft_limit_min (soft_min_reg),
        .max_torque     (max_torque_reg),
        .offset_min     (offset_min_reg),
        .offset_max     (offset_max_reg),
        .dead_zone      (dead_zone_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .target_pos     (s_axis_tdata[PB-1:0]),
        .measured_pos   (s_axis_tdata[2*PB-1:PB]),
        .out_valid      (fr_valid),
        .out_ready      (fr_ready),
        .out_tmag       (fr_tmag),
        .out_fac_dz     (fr_fac_dz),
        .out_fac_min    (fr_fac_min),
        .out_offset     (fr_offset),
        .out_flags      (fr_flags)
    );

    // Dead-zone scaling: torque * distance / dead_zone.
    sddt_scale #(
        .SIDE_W (SIDE1_W)
    ) u_scale_dz (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_tmag   (fr_tmag),
        .in_factor (fr_fac_dz),
        .in_apply  (fr_flags.in_dz),
        .in_side   ({fr_fac_min, fr_offset, fr_flags.neg, fr_flags.below}),
        .divisor   (dead_zone_reg),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_tmag  (s1_tmag),
        .out_side  (s1_side)
    );

    assign {s1_fac_min, s1_offset, s1_neg, s1_below} = s1_side;

    // Minimum-offset scaling: torque * offset / offset_min.
    sddt_scale #(
        .SIDE_W (SIDE2_W)
    ) u_scale_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_tmag   (s1_tmag),
        .in_factor (s1_fac_min),
        .in_apply  (s1_below),
        .in_side   ({s1_offset, s1_neg}),
        .divisor   (offset_min_reg),
        .out_valid (s2_valid),
        .out_ready (out_rdy),
        .out_tmag  (s2_tmag),
        .out_side  (s2_side)
    );

    assign {s2_offset, s2_neg} = s2_side;

    assign out_rdy     = ~out_v_reg | m_axis_tready;
    assign tq_ext      = TORQUE_OUT_W'(s2_tmag);
    assign torque_next = s2_neg ? (TORQUE_OUT_W'(0) - tq_ext) : tq_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_v_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            out_data_reg <= {s2_offset, torque_next};
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

    assign out_torque     = m_axis_tdata[TORQUE_OUT_W-1:0];
    assign out_torque_mag = out_torque[TORQUE_OUT_W-1] ? (TORQUE_OUT_W'(0) - out_torque)
                                                       : out_torque;

    a_torque_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_torque_mag <= TORQUE_OUT_W'(max_torque_reg)))
        else $error("torque magnitude above max_torque");

    a_offset_capped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:TORQUE_OUT_W] <= offset_max_reg))
        else $error("drive offset above offset_max");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output is free");

endmodule

FILE: tb/tb_stepper_direct_drive_torque.sv
// Self-checking testbench for stepper_direct_drive_torque: directed and random
// position items against a built-in torque and offset predictor.
// Depends on sddt_pkg and the stepper_direct_drive_torque RTL only.

module tb_stepper_direct_drive_torque;
    import sddt_pkg::*;

    localparam int POS_W        = 24;
    localparam int ENC_W        = 14;
    localparam int STEP_CYCLE   = (4 * (1 << ENC_W)) / 200;
    localparam int PHASE_SCALE  = 256;
    localparam int DUT_LATENCY  = 39;
    localparam int STALL_LIMIT  = 3000;
    localparam int SEGMENT_LEN  = 150;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OFFSET_W-1:0]            offset;
        logic signed [TORQUE_OUT_W-1:0] torque;
    } drive_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]              paddr = '0;
    logic [CFG_DATA_W-1:0]              pwdata = '0;
    logic [CFG_DATA_W-1:0]              prdata;
    logic                               pready;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // Fields from bit 0: target_pos, measured_pos.
    logic [2*POS_W-1:0]                 s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // Fields from bit 0: torque_out, drive_offset.
    logic [TORQUE_OUT_W+OFFSET_W-1:0]   m_axis_tdata;

    logic signed [POS_W-1:0]    lim_hi;
    logic signed [POS_W-1:0]    lim_lo;
    logic [TORQUE_W-1:0]        torque_full;
    logic [OFFSET_W-1:0]        ofs_floor;
    logic [OFFSET_W-1:0]        ofs_ceiling;
    logic [OFFSET_W-1:0]        dead_band;

    drive_result_t  expected_drive[$];
    int             mismatches = 0;
    int             stall_cycles = 0;
    int             tx_gap_pct = 0;
    int             rx_stall_pct = 0;

    stepper_direct_drive_torque #(
        .POSITION_BITS(POS_W),
        .ENCODER_BITS (ENC_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic drive_result_t drive_command(input logic signed [POS_W-1:0] tgt_in,
                                                    input logic signed [POS_W-1:0] meas_in);
        longint        tgt;
        longint        meas;
        longint        hi;
        longint        lo;
        longint        delta;
        longint        dist_abs;
        longint        ofs;
        longint        trq;
        longint        full;
        longint        band;
        longint        floor_v;
        longint        ceil_v;
        drive_result_t res;
        tgt = tgt_in;
        meas = meas_in;
        hi = lim_hi;
        lo = lim_lo;
        full = torque_full;
        band = dead_band;
        floor_v = ofs_floor;
        ceil_v = ofs_ceiling;
        if (hi > lo)
        begin
            if (tgt > hi)
                tgt = hi;
            if (tgt < lo)
                tgt = lo;
        end
        delta = tgt - meas;
        ofs = (delta * PHASE_SCALE) / STEP_CYCLE;
        if (ofs == 0)
            trq = 0;
        else if (ofs < 0)
            trq = -full;
        else
            trq = full;
        dist_abs = (delta < 0) ? -delta : delta;
        if (dist_abs < band)
            trq = (trq * dist_abs) / band;
        if (ofs < 0)
            ofs = -ofs;
        if (ofs < floor_v)
        begin
            trq = (trq * ofs) / floor_v;
            ofs = floor_v;
        end
        if (ofs > ceil_v)
            ofs = ceil_v;
        res.torque = trq[TORQUE_OUT_W-1:0];
        res.offset = ofs[OFFSET_W-1:0];
        return res;
    endfunction

    task automatic log_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(negedge clk)
    begin : check_results
        drive_result_t want;
        drive_result_t got;
        got = m_axis_tdata;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_drive.size() == 0)
            begin
                log_mismatch("unexpected item, torque_out", 0, got.torque);
            end
            else
            begin
                want = expected_drive.pop_front();
                if (got.torque !== want.torque)
                    log_mismatch("torque_out", want.torque, got.torque);
                if (got.offset !== want.offset)
                    log_mismatch("drive_offset", want.offset, got.offset);
            end
        end
    end

    always @(negedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_SOFT_LIMIT_MAX: lim_hi = val[POS_W-1:0];
            REG_SOFT_LIMIT_MIN: lim_lo = val[POS_W-1:0];
            REG_MAX_TORQUE:     torque_full = val[TORQUE_W-1:0];
            REG_OFFSET_MIN:     ofs_floor = val[OFFSET_W-1:0];
            REG_OFFSET_MAX:     ofs_ceiling = val[OFFSET_W-1:0];
            REG_DEAD_ZONE:      dead_band = val[OFFSET_W-1:0];
            default:            ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input logic signed [POS_W-1:0] hi, input logic signed [POS_W-1:0] lo,
                               input logic [TORQUE_W-1:0] full, input logic [OFFSET_W-1:0] floor_v,
                               input logic [OFFSET_W-1:0] ceil_v, input logic [OFFSET_W-1:0] band);
        apb_write(REG_SOFT_LIMIT_MAX, {{(CFG_DATA_W-POS_W){hi[POS_W-1]}}, hi});
        apb_write(REG_SOFT_LIMIT_MIN, {{(CFG_DATA_W-POS_W){lo[POS_W-1]}}, lo});
        apb_write(REG_MAX_TORQUE, CFG_DATA_W'(full));
        apb_write(REG_OFFSET_MIN, CFG_DATA_W'(floor_v));
        apb_write(REG_OFFSET_MAX, CFG_DATA_W'(ceil_v));
        apb_write(REG_DEAD_ZONE, CFG_DATA_W'(band));
    endtask

    task automatic send_position(input logic signed [POS_W-1:0] tgt,
                                 input logic signed [POS_W-1:0] meas);
        logic taken;
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {meas, tgt};
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end while (!taken);
        expected_drive.push_back(drive_command(tgt, meas));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (DUT_LATENCY + 4) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_position(24'sd1000, 24'sd0);
        send_position(-24'sd8388608, 24'sd8388607);
        send_position(24'sd0, 24'sd0);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        load_config(24'sd1000, -24'sd1000, 15'h7FFF, 16'd100, 16'd2000, 16'd500);
        send_position(24'sd8388607, -24'sd8388608);
        send_position(-24'sd8388608, 24'sd8388607);
        send_position(24'sd8388607, 24'sd8388607);
        send_position(-24'sd8388608, -24'sd8388608);
        send_position(24'sd1, 24'sd0);
        send_position(-24'sd2, 24'sd0);
        send_position(24'sd300, 24'sd0);
        send_position(24'sd0, 24'sd600);
        wait_drained();
    endtask

    task automatic test_unordered_limits();
        load_config(-24'sd1000, 24'sd1000, 15'd20000, 16'd0, 16'hFFFF, 16'd0);
        send_position(24'sd5000, 24'sd0);
        send_position(-24'sd5000, 24'sd0);
        wait_drained();
        apb_write(REG_SOFT_LIMIT_MIN, -32'sd1000 + 32'sd2000);
        apb_write(REG_SOFT_LIMIT_MAX, 32'd1000);
        send_position(24'sd8388607, 24'sd0);
        send_position(-24'sd8388608, 24'sd0);
        wait_drained();
    endtask

    task automatic test_no_scaling();
        load_config(24'sd8388607, -24'sd8388608, 15'h7FFF, 16'd0, 16'hFFFF, 16'd0);
        send_position(24'sd1, 24'sd0);
        send_position(24'sd2, 24'sd0);
        send_position(-24'sd2, 24'sd0);
        send_position(24'sd8388607, -24'sd8388608);
        wait_drained();
    endtask

    task automatic test_floor_above_ceiling();
        load_config(24'sd0, 24'sd0, 15'd12345, 16'd60000, 16'd10, 16'hFFFF);
        send_position(24'sd40000, 24'sd0);
        send_position(-24'sd70000, 24'sd0);
        send_position(24'sd0, 24'sd0);
        send_position(24'sd8388607, -24'sd8388608);
        wait_drained();
    endtask

    task automatic test_spare_registers();
        load_config(24'sd500, -24'sd500, 15'd30000, 16'd50, 16'd40000, 16'd300);
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        send_position(24'sd2000, 24'sd100);
        send_position(-24'sd20, 24'sd100);
        wait_drained();
    endtask

    function automatic logic [OFFSET_W-1:0] pick_u16(input int typical);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return OFFSET_W'($urandom_range(0, typical));
            default: return OFFSET_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position();
        case ($urandom_range(0, 4))
            0:       return {1'b0, {(POS_W-1){1'b1}}};
            1:       return {1'b1, {(POS_W-1){1'b0}}};
            2, 3:    return POS_W'($urandom_range(0, 8192) - 4096);
            default: return POS_W'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] tmp;
        logic [TORQUE_W-1:0]     full;
        hi = pick_position();
        lo = pick_position();
        if ((hi < lo) && ($urandom_range(0, 3) != 0))
        begin
            tmp = hi;
            hi = lo;
            lo = tmp;
        end
        case ($urandom_range(0, 3))
            0:       full = '0;
            1:       full = '1;
            default: full = TORQUE_W'($urandom);
        endcase
        load_config(hi, lo, full, pick_u16(600), pick_u16(4000), pick_u16(2000));
    endtask

    task automatic send_random_position();
        longint                  meas;
        longint                  tgt;
        longint                  span;
        logic signed [POS_W-1:0] meas_f;
        logic signed [POS_W-1:0] tgt_f;
        case ($urandom_range(0, 3))
            0:       span = 4;
            1:       span = 400;
            2:       span = 3000;
            default: span = 70000;
        endcase
        meas_f = POS_W'($urandom);
        meas = meas_f;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                tgt = longint'($signed(POS_W'($urandom)));
            end
            2, 3, 4, 5:
            begin
                tgt = meas + longint'($urandom_range(0, 2 * span)) - span;
            end
            6, 7:
            begin
                meas = (($urandom_range(0, 1) != 0) ? longint'(lim_hi) : longint'(lim_lo))
                       + longint'($urandom_range(0, 2 * span)) - span;
                tgt = ($urandom_range(0, 1) != 0) ? longint'($signed(POS_W'($urandom)))
                                                   : meas + longint'($urandom_range(0, 2 * span)) - span;
            end
            8:
            begin
                meas = longint'(pick_position());
                tgt = longint'(pick_position());
            end
            default:
            begin
                tgt = meas;
            end
        endcase
        meas_f = meas[POS_W-1:0];
        tgt_f = tgt[POS_W-1:0];
        send_position(tgt_f, meas_f);
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct);
        tx_gap_pct = gap_pct;
        rx_stall_pct = stall_pct;
        repeat (3)
        begin
            randomize_config();
            repeat (SEGMENT_LEN) send_random_position();
            wait_drained();
        end
    endtask

    initial
    begin
        lim_hi = '0;
        lim_lo = '0;
        torque_full = '0;
        ofs_floor = '0;
        ofs_ceiling = OFFSET_MAX_RESET;
        dead_band = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_unordered_limits();
        test_no_scaling();
        test_floor_above_ceiling();
        test_spare_registers();
        test_random_phase(25, 62);
        test_random_phase(62, 25);
        test_random_phase(0, 0);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/sddt_pkg.sv
src/sddt_div.sv
src/sddt_scale.sv
src/sddt_front.sv
src/stepper_direct_drive_torque.sv
tb/tb_stepper_direct_drive_torque.sv
